// ----- hdl/pip_pkg.sv -----
// ---------------------------------------------------------------------------
// pip_pkg : shared types for the point-in-polygon counter
// Item kinds decided by the front end and the queued item format.
// ---------------------------------------------------------------------------
package pip_pkg;

   // kind of a queued item, decided when the item is taken in
   typedef enum logic [1:0] {
      KIND_LOAD  = 2'b00,
      KIND_QUERY = 2'b01,
      KIND_SKIP  = 2'b10
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  slot;
      logic [15:0] x;
      logic [15:0] y;
   } item_type;

   localparam int unsigned VCOUNT_W  = 9;
   localparam int unsigned VCOUNT_MIN = 3;
   localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

endpackage

// ----- hdl/pip_front.sv -----
// ---------------------------------------------------------------------------
// pip_front : request intake and classification
// Takes request items, sorts them into load, query or dropped load, and
// holds them in a two-entry queue for the walk engine.
// ---------------------------------------------------------------------------
module pip_front #(
   parameter int MAX_VERTICES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [7:0]        req_vertex_index,
   input  logic [15:0]       req_x_coord,
   input  logic [15:0]       req_y_coord,
   output logic              head_valid,
   output pip_pkg::item_type head_item,
   input  logic              head_pop
);

   pip_pkg::item_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, pop;
   pip_pkg::item_type new_item;

   assign req_ready  = (cnt_ff != 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_item  = q_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = head_valid && head_pop;

   always_comb begin
      new_item.slot = req_vertex_index;
      new_item.x    = req_x_coord;
      new_item.y    = req_y_coord;
      priority if (req_op) begin
         new_item.kind = pip_pkg::KIND_QUERY;
      end else if (32'(req_vertex_index) < 32'(MAX_VERTICES)) begin
         new_item.kind = pip_pkg::KIND_LOAD;
      end else begin
         // slot beyond the store, nothing to do
         new_item.kind = pip_pkg::KIND_SKIP;
      end
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- hdl/pip_walk.sv -----
// ---------------------------------------------------------------------------
// pip_walk : vertex store and winding number engine
// Writes loads into the vertex store; for a query reads the ring one vertex
// a cycle and runs each edge through a three-stage cross product pipeline.
// ---------------------------------------------------------------------------
module pip_walk #(
   parameter int MAX_VERTICES = 256,
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
   localparam int CW = $clog2(MAX_VERTICES + 1),
   localparam int WW = CW + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CW-1:0]     ring_len,
   input  logic              head_valid,
   input  pip_pkg::item_type head_item,
   output logic              head_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_inside_res,
   output logic [15:0]       rsp_inside_total
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   localparam logic signed [WW-1:0] WnPlus  = WW'(1);
   localparam logic signed [WW-1:0] WnMinus = WW'(-1);

   state_type state_ff, state_in;

   // vertex store, x low half, y high half
   logic [31:0]       mem [MAX_VERTICES];
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [31:0]       rd_data_ff;

   logic [CW-1:0]     k_ff, k_in;
   logic signed [15:0] qx_ff, qy_ff;

   // read stage flags
   logic              rd_valid_ff, rd_first_ff, rd_last_ff;
   logic signed [15:0] ax_ff, ay_ff;
   logic signed [15:0] bx, by;

   // stage one: differences and ray tests
   logic              s1_valid_ff, s1_last_ff;
   logic signed [16:0] dx_ab_ff, dy_pa_ff, dx_pa_ff, dy_ab_ff;
   logic              s1_up_ff, s1_down_ff, s1_box_ff;
   logic              up_in, down_in, box_in;
   logic signed [15:0] lox, hix, loy, hiy;

   // stage two: products
   logic              s2_valid_ff, s2_last_ff;
   logic signed [33:0] p1_ff, p2_ff;
   logic              s2_up_ff, s2_down_ff, s2_box_ff;

   // stage three: side sign and accumulation
   logic signed [34:0] side;
   logic signed [WW-1:0] wn_ff, wn_in;
   logic              hit_ff, hit_in;

   logic              rsp_valid_ff, rsp_res_ff;
   logic [15:0]       total_ff, total_in;
   logic              in_poly, finish_go;

   // sequencer
   always_comb begin
      state_in = state_ff;
      head_pop = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      k_in     = k_ff;
      finish_go = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               unique case (head_item.kind)
                  pip_pkg::KIND_LOAD: begin
                     wr_en = 1'b1;
                  end
                  pip_pkg::KIND_QUERY: begin
                     k_in     = '0;
                     state_in = ST_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            rd_en = 1'b1;
            if (k_ff == ring_len) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (s2_valid_ff && s2_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               finish_go = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // the ring closes by reading vertex zero once more
   assign rd_addr = (k_ff == ring_len) ? '0 : k_ff[AW-1:0];
   assign wr_addr = AW'(head_item.slot);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {head_item.y, head_item.x};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && head_valid && head_item.kind == pip_pkg::KIND_QUERY) begin
         qx_ff <= head_item.x;
         qy_ff <= head_item.y;
      end
   end

   assign bx = rd_data_ff[15:0];
   assign by = rd_data_ff[31:16];

   always_comb begin
      lox     = (ax_ff < bx) ? ax_ff : bx;
      hix     = (ax_ff < bx) ? bx : ax_ff;
      loy     = (ay_ff < by) ? ay_ff : by;
      hiy     = (ay_ff < by) ? by : ay_ff;
      up_in   = (ay_ff <= qy_ff) && (by > qy_ff);
      down_in = (ay_ff > qy_ff) && (by <= qy_ff);
      box_in  = (qx_ff >= lox) && (qx_ff <= hix) && (qy_ff >= loy) && (qy_ff <= hiy);
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         ax_ff <= bx;
         ay_ff <= by;
      end
      dx_ab_ff   <= {bx[15], bx} - {ax_ff[15], ax_ff};
      dy_pa_ff   <= {qy_ff[15], qy_ff} - {ay_ff[15], ay_ff};
      dx_pa_ff   <= {qx_ff[15], qx_ff} - {ax_ff[15], ax_ff};
      dy_ab_ff   <= {by[15], by} - {ay_ff[15], ay_ff};
      s1_up_ff   <= up_in;
      s1_down_ff <= down_in;
      s1_box_ff  <= box_in;
      s1_last_ff <= rd_last_ff;
      p1_ff      <= dx_ab_ff * dy_pa_ff;
      p2_ff      <= dx_pa_ff * dy_ab_ff;
      s2_up_ff   <= s1_up_ff;
      s2_down_ff <= s1_down_ff;
      s2_box_ff  <= s1_box_ff;
      s2_last_ff <= s1_last_ff;
      rd_first_ff <= (k_ff == '0);
      rd_last_ff  <= (k_ff == ring_len);
   end

   assign side = {p1_ff[33], p1_ff} - {p2_ff[33], p2_ff};

   always_comb begin
      wn_in  = wn_ff;
      hit_in = hit_ff;
      if (state_ff == ST_IDLE) begin
         wn_in  = '0;
         hit_in = 1'b0;
      end else if (s2_valid_ff) begin
         // on the edge line and inside its box means on the boundary
         if (side == '0 && s2_box_ff) begin
            hit_in = 1'b1;
         end
         if (s2_up_ff && !side[34] && side != '0) begin
            wn_in = wn_ff + WnPlus;
         end else if (s2_down_ff && side[34]) begin
            wn_in = wn_ff + WnMinus;
         end
      end
   end

   assign in_poly  = !hit_ff && (wn_ff == WnPlus || wn_ff == WnMinus);
   assign total_in = (in_poly && total_ff != pip_pkg::TOTAL_MAX) ? total_ff + 16'd1 : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rd_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         wn_ff        <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         k_ff        <= k_in;
         rd_valid_ff <= rd_en;
         // the first vertex read only opens the ring
         s1_valid_ff <= rd_valid_ff && !rd_first_ff;
         s2_valid_ff <= s1_valid_ff;
         wn_ff       <= wn_in;
         hit_ff      <= hit_in;
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
            total_ff     <= total_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_res_ff <= in_poly;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inside_res   = rsp_res_ff;
   assign rsp_inside_total = total_ff;

endmodule

// ----- hdl/point_in_polygon_counter_top.sv -----
// ---------------------------------------------------------------------------
// point_in_polygon_counter_top : integer point-in-polygon counter
// Exact winding number test of query points against a stored polygon.
// ---------------------------------------------------------------------------
// Load items (op 0) write one vertex into the store and give no response;
// query items (op 1) give one response with the inside flag and a saturating
// count of inside queries. For a query the engine reads one vertex a cycle
// from the single-port store, walking the ring and reading vertex zero again
// to close it, then drains a three-stage cross product pipeline. Requests are
// taken into a two-entry queue while the engine works or a response waits.
// The store has no reset; every vertex in use must be loaded before a query.
// vertex_count is clamped to 3 .. MAX_VERTICES and must only be written
// while the block is idle.
module point_in_polygon_counter_top #(
   parameter int MAX_VERTICES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_vertex_index,
   input  logic [15:0] req_x_coord,
   input  logic [15:0] req_y_coord,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_inside_res,
   output logic [15:0] rsp_inside_total,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);

   localparam int CW = $clog2(MAX_VERTICES + 1);

   logic [pip_pkg::VCOUNT_W-1:0] vcount_ff;
   logic [CW-1:0]                ring_len;
   logic                         head_valid, head_pop;
   pip_pkg::item_type            head_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= pip_pkg::VCOUNT_W'(pip_pkg::VCOUNT_MIN);
      end else if (csr_wr_en) begin
         vcount_ff <= csr_wr_data;
      end
   end

   always_comb begin
      priority if (32'(vcount_ff) < pip_pkg::VCOUNT_MIN) begin
         ring_len = CW'(pip_pkg::VCOUNT_MIN);
      end else if (32'(vcount_ff) > 32'(MAX_VERTICES)) begin
         ring_len = CW'(MAX_VERTICES);
      end else begin
         ring_len = CW'(vcount_ff);
      end
   end

   pip_front #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_vertex_index (req_vertex_index),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .head_pop         (head_pop)
   );

   pip_walk #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_walk (
      .clock            (clock),
      .reset            (reset),
      .ring_len         (ring_len),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .head_pop         (head_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_inside_total (rsp_inside_total)
   );

endmodule

// ----- hdl/pip_checker.sv -----
// ---------------------------------------------------------------------------
// pip_checker : port-level checks for the point-in-polygon counter
// Watches the top level ports and is bound to every instance of it.
// ---------------------------------------------------------------------------
module pip_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_inside_res,
   input logic [15:0] rsp_inside_total
);

   // a held response keeps its contents until the transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inside_res)
         && $stable(rsp_inside_total))
      else $error("response changed while stalled");

   // an inside result has always been counted
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |-> rsp_inside_total != 16'd0)
      else $error("inside result with zero total");

   // reset empties the queue and the response register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

endmodule

bind point_in_polygon_counter_top pip_checker u_pip_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_inside_res   (rsp_inside_res),
   .rsp_inside_total (rsp_inside_total)
);
